// File: rtl/core/dmxpf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmxpf_pkg
// Types, codes and the header byte table shared by the DMX packet framer.
// ----------------------------------------------------------------------------
package dmxpf_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_BAD_CHANNEL = 2'd1,
    STAT_BAD_OFFSET  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_VERSION    = 2'd0,
    REG_UNIVERSE   = 2'd1,
    REG_PORT       = 2'd2,
    REG_SLOT0_CODE = 2'd3
  } reg_idx_t;

  typedef enum logic {
    S_CLEAR = 1'b0,
    S_RUN   = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]  protocol_version;
    logic [31:0] universe;
    logic [7:0]  port_number;
    logic [15:0] slot0_code;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic sweep;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } dp_status_t;

  localparam logic [1:0]  VERSION_1        = 2'd1;
  localparam logic [1:0]  RESET_VERSION    = 2'd2;
  localparam logic [31:0] RESET_UNIVERSE   = 32'hFFFF_FFFF;
  localparam logic [7:0]  RESET_PORT       = 8'h00;
  localparam logic [15:0] RESET_SLOT0_CODE = 16'h0FFF;

  localparam logic [9:0] HDR_LEN_V1 = 10'd20;
  localparam logic [9:0] HDR_LEN_V2 = 10'd24;

  localparam logic [7:0] MAGIC0      = 8'h04;
  localparam logic [7:0] MAGIC1      = 8'h01;
  localparam logic [7:0] MAGIC2      = 8'hDC;
  localparam logic [7:0] MAGIC3      = 8'h4A;
  localparam logic [7:0] VER_MAJOR   = 8'h01;
  localparam logic [7:0] TYPE_V1     = 8'h08;
  localparam logic [7:0] TYPE_V2     = 8'h01;
  localparam logic [7:0] TYPE_HI     = 8'h01;
  localparam logic [7:0] V2_FLAG_HI  = 8'h02;

  // Header byte at offsets below the header length.
  function automatic logic [7:0] header_byte(input logic [4:0] off, input cfg_t cfg);
    logic       v1;
    logic [7:0] b;
    v1 = (cfg.protocol_version == VERSION_1);
    b  = 8'h00;
    if (off < 5'd12) begin
      case (off)
        5'd0:    b = MAGIC0;
        5'd1:    b = MAGIC1;
        5'd2:    b = MAGIC2;
        5'd3:    b = MAGIC3;
        5'd4:    b = VER_MAJOR;
        5'd6:    b = v1 ? TYPE_V1 : TYPE_V2;
        5'd7:    b = TYPE_HI;
        default: b = 8'h00;
      endcase
    end else if (v1) begin
      case (off)
        5'd12:   b = cfg.port_number;
        5'd16:   b = cfg.universe[7:0];
        5'd17:   b = cfg.universe[15:8];
        5'd18:   b = cfg.universe[23:16];
        5'd19:   b = cfg.universe[31:24];
        default: b = 8'h00;
      endcase
    end else begin
      case (off)
        5'd12:   b = cfg.universe[7:0];
        5'd13:   b = cfg.universe[15:8];
        5'd14:   b = cfg.universe[23:16];
        5'd15:   b = cfg.universe[31:24];
        5'd16:   b = cfg.port_number;
        5'd21:   b = V2_FLAG_HI;
        5'd22:   b = cfg.slot0_code[7:0];
        5'd23:   b = cfg.slot0_code[15:8];
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/dmxpf_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmxpf_regs
// APB configuration registers: version, universe, port and start code.
// ----------------------------------------------------------------------------
module dmxpf_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output dmxpf_pkg::cfg_t        cfg
);
  import dmxpf_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_version <= RESET_VERSION;
      cfg.universe         <= RESET_UNIVERSE;
      cfg.port_number      <= RESET_PORT;
      cfg.slot0_code       <= RESET_SLOT0_CODE;
    end else if (wr_en) begin
      unique case (idx)
        REG_VERSION:    cfg.protocol_version <= pwdata[1:0];
        REG_UNIVERSE:   cfg.universe         <= pwdata;
        REG_PORT:       cfg.port_number      <= pwdata[7:0];
        REG_SLOT0_CODE: cfg.slot0_code       <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_VERSION:    prdata = {30'd0, cfg.protocol_version};
      REG_UNIVERSE:   prdata = cfg.universe;
      REG_PORT:       prdata = {24'd0, cfg.port_number};
      REG_SLOT0_CODE: prdata = {16'd0, cfg.slot0_code};
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/dmxpf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmxpf_ctrl
// Controller: store clearing sweep after reset or clear request, else serve.
// ----------------------------------------------------------------------------
module dmxpf_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [1:0]            req_type,
  input  dmxpf_pkg::dp_status_t      dp_stat,
  output logic                       busy,
  output dmxpf_pkg::ctrl_cmd_t       cmd
);
  import dmxpf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_RUN: begin
        if (start && (req_t'(req_type) == REQ_CLEAR)) begin
          state_next = S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (dp_stat.sweep_last) begin
          state_next = S_RUN;
        end
      end
    endcase
  end

  always_comb begin
    busy       = (state == S_CLEAR);
    cmd.sweep  = (state == S_CLEAR);
    cmd.accept = (state == S_RUN) && start;
  end

endmodule
`default_nettype wire

// File: rtl/core/dmxpf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmxpf_dp
// Datapath: channel level memory, header table, result registers.
// ----------------------------------------------------------------------------
module dmxpf_dp #(
  parameter int CHANNEL_COUNT = 512
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  dmxpf_pkg::ctrl_cmd_t       cmd,
  input  dmxpf_pkg::cfg_t            cfg,
  input  wire logic [1:0]            req_type,
  input  wire logic [9:0]            channel,
  input  wire logic [7:0]            value,
  input  wire logic [9:0]            offset,
  output dmxpf_pkg::dp_status_t      dp_stat,
  output logic                       done,
  output logic [7:0]                 packet_byte,
  output logic [9:0]                 packet_length,
  output logic [1:0]                 status
);
  import dmxpf_pkg::*;

  localparam int         ADDR_W    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [9:0] CH_MAX    = 10'(CHANNEL_COUNT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CHANNEL_COUNT - 1);

  logic [7:0]        mem [CHANNEL_COUNT];
  logic [ADDR_W-1:0] cnt;
  logic [7:0]        rdata;

  logic [9:0]        hlen;
  logic [9:0]        plen;
  logic [9:0]        ch_m1;
  logic [9:0]        idx;
  logic              chan_ok;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;

  logic [7:0]        byte_next;
  logic              sel_mem_next;
  status_t           stat_next;

  logic [7:0]        byte_q;
  logic              sel_mem_q;
  status_t           stat_q;
  logic [9:0]        plen_q;

  assign hlen    = (cfg.protocol_version == VERSION_1) ? HDR_LEN_V1 : HDR_LEN_V2;
  assign plen    = hlen + CH_MAX;
  assign ch_m1   = channel - 10'd1;
  assign idx     = offset - hlen;
  assign chan_ok = (channel != 10'd0) && (channel <= CH_MAX);

  assign we    = cmd.sweep ||
                 (cmd.accept && (req_t'(req_type) == REQ_WRITE) && chan_ok);
  assign waddr = cmd.sweep ? cnt : ch_m1[ADDR_W-1:0];
  assign wdata = cmd.sweep ? 8'h00 : value;

  assign dp_stat.sweep_last = (cnt == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.accept) begin
      rdata <= mem[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.sweep && !dp_stat.sweep_last) begin
      cnt <= cnt + ADDR_W'(1);
    end else begin
      cnt <= '0;
    end
  end

  always_comb begin
    byte_next    = 8'h00;
    sel_mem_next = 1'b0;
    stat_next    = STAT_OK;
    unique case (req_t'(req_type))
      REQ_WRITE: begin
        stat_next = chan_ok ? STAT_OK : STAT_BAD_CHANNEL;
      end
      REQ_READ: begin
        priority if (offset >= plen) begin
          stat_next = STAT_BAD_OFFSET;
        end else if (offset < hlen) begin
          byte_next = header_byte(offset[4:0], cfg);
        end else begin
          sel_mem_next = 1'b1;
        end
      end
      default: begin
        stat_next = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.accept;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_q    <= byte_next;
      sel_mem_q <= sel_mem_next;
      stat_q    <= stat_next;
      plen_q    <= plen;
    end
  end

  assign packet_byte   = sel_mem_q ? rdata : byte_q;
  assign packet_length = plen_q;
  assign status        = stat_q;

endmodule
`default_nettype wire

// File: rtl/core/dmx_packet_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dmx_packet_framer
// Latency: an accepted request has its result (done) in the next cycle.
// Throughput: one write or read request per cycle; busy stays low between them.
// A clear request holds busy while the level memory is
// swept one entry per cycle through its single write port.
// Reset (rst, synchronous) loads register defaults and runs the same sweep.
// The receiver cannot stall: done marks each result for exactly one cycle.
// ----------------------------------------------------------------------------
module dmx_packet_framer #(
  parameter int CHANNEL_COUNT = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [9:0]  channel,
  input  wire logic [7:0]  value,
  input  wire logic [9:0]  offset,
  output logic             done,
  output logic [7:0]       packet_byte,
  output logic [9:0]       packet_length,
  output logic [1:0]       status
);
  import dmxpf_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t dp_stat;

  dmxpf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dmxpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .dp_stat  (dp_stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  dmxpf_dp #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg),
    .req_type      (req_type),
    .channel       (channel),
    .value         (value),
    .offset        (offset),
    .dp_stat       (dp_stat),
    .done          (done),
    .packet_byte   (packet_byte),
    .packet_length (packet_length),
    .status        (status)
  );

endmodule
`default_nettype wire
